### rtl/brdg_pkg.sv
package brdg_pkg;

  // Fixed field widths
  localparam int CompW   = 16;
  localparam int VecW    = 3 * CompW;
  localparam int ColInW  = 10;
  localparam int RowInW  = 9;
  localparam int InDataW = 24;
  localparam int CfgIdxW = 2;

  // Pipeline depth: one clamp stage, then two blend passes
  localparam int BlendStages = 5;
  localparam int NumStages   = 1 + 2 * BlendStages;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgTopLeft     = 2'd0,
    CfgTopRight    = 2'd1,
    CfgBottomLeft  = 2'd2,
    CfgBottomRight = 2'd3
  } cfg_idx_e;

  // Packed direction vector, x in the high bits
  typedef struct packed {
    logic signed [CompW-1:0] x;
    logic signed [CompW-1:0] y;
    logic signed [CompW-1:0] z;
  } vec_t;

  typedef logic [NumStages-1:0] stage_en_t;

endpackage

### rtl/brdg_ctrl.sv
module brdg_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output brdg_pkg::stage_en_t en_o
);
  import brdg_pkg::*;

  stage_en_t vld_q, vld_d;
  stage_en_t en;

  // Stage k may load when it is empty or its content moves on
  always_comb begin
    en[NumStages-1] = !vld_q[NumStages-1] || out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  // Valid bits travel with the data
  always_comb begin
    vld_d[0] = en[0] ? in_valid_i : vld_q[0];
    for (int k = 1; k < NumStages; k++) begin
      vld_d[k] = en[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign en_o        = en;
  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[NumStages-1];

endmodule

### rtl/brdg_blend.sv
// a + trunc((b - a) * n / DEN), five register stages.
// Division by DEN is a reciprocal multiply plus one correction step.
module brdg_blend #(
  parameter int DEN = 479,
  parameter int NW  = 9
) (
  input  logic                                clk_i,
  input  logic [brdg_pkg::BlendStages-1:0]    en_i,
  input  logic signed [brdg_pkg::CompW-1:0]   a_i,
  input  logic signed [brdg_pkg::CompW-1:0]   b_i,
  input  logic [NW-1:0]                       n_i,
  output logic signed [brdg_pkg::CompW-1:0]   v_o
);
  import brdg_pkg::*;

  localparam int DW = $clog2(DEN + 1);
  localparam int XW = CompW + DW;          // |b - a| * n < 2**XW
  localparam int Sh = XW;                  // reciprocal scale
  localparam int PW = XW + Sh + 1;
  localparam int RW = XW + DW;
  localparam logic [63:0] Recip = (64'd1 << Sh) / 64'(DEN);

  // Stage 1: difference, sign and magnitude
  logic signed [CompW:0]   diff;
  logic signed [CompW:0]   diff_neg;
  logic                    neg1_q;
  logic [CompW-1:0]        mag1_q;
  logic signed [CompW-1:0] a1_q;
  logic [NW-1:0]           n1_q;

  assign diff     = {b_i[CompW-1], b_i} - {a_i[CompW-1], a_i};
  assign diff_neg = -diff;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      a1_q   <= a_i;
      n1_q   <= n_i;
      neg1_q <= diff[CompW];
      mag1_q <= diff[CompW] ? diff_neg[CompW-1:0] : diff[CompW-1:0];
    end
  end

  // Stage 2: scaled magnitude
  logic [XW-1:0]           x2_q;
  logic                    neg2_q;
  logic signed [CompW-1:0] a2_q;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      x2_q   <= XW'(mag1_q) * XW'(n1_q);
      neg2_q <= neg1_q;
      a2_q   <= a1_q;
    end
  end

  // Stage 3: quotient estimate, low by at most one
  logic [PW-1:0]           prod;
  logic [XW-1:0]           x3_q;
  logic [XW-1:0]           qe3_q;
  logic                    neg3_q;
  logic signed [CompW-1:0] a3_q;

  assign prod = PW'(x2_q) * PW'(Recip[Sh:0]);

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      x3_q   <= x2_q;
      qe3_q  <= prod[Sh +: XW];
      neg3_q <= neg2_q;
      a3_q   <= a2_q;
    end
  end

  // Stage 4: remainder check and correction
  logic [RW-1:0]           qd;
  logic [RW-1:0]           rem;
  logic [XW-1:0]           q_fix;
  logic [CompW-1:0]        q4_q;
  logic                    neg4_q;
  logic signed [CompW-1:0] a4_q;

  assign qd    = RW'(qe3_q) * RW'(DEN);
  assign rem   = RW'(x3_q) - qd;
  assign q_fix = qe3_q + XW'(rem >= RW'(DEN));

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      q4_q   <= q_fix[CompW-1:0];
      neg4_q <= neg3_q;
      a4_q   <= a3_q;
    end
  end

  // Stage 5: signed step added to the start point
  logic signed [CompW:0]   step;
  logic signed [CompW:0]   sum;
  logic signed [CompW-1:0] v5_q;

  assign step = neg4_q ? -$signed({1'b0, q4_q}) : $signed({1'b0, q4_q});
  assign sum  = {a4_q[CompW-1], a4_q} + step;

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      v5_q <= sum[CompW-1:0];
    end
  end

  assign v_o = v5_q;

endmodule

### rtl/bilinear_ray_direction_grid_unit.sv
// Ray direction generator for a raster of GRID_WIDTH x GRID_HEIGHT pixels.
// Input channel (s_t*): one pixel per transfer, column and row.
// Output channel (m_t*): one direction vector per pixel, in input order,
// the bilinear blend of the four corner vectors at that pixel. Columns
// and rows past the grid edge are clamped to the last column or row.
// Config port: write corner vectors while no pixel is in flight; a write
// lands on the clock edge where cfg_we_i is high.
// The pipeline is one clamp stage, then two five-stage blend passes
// (edges over the row, then across over the column). Each blend divides
// by a constant through a reciprocal multiply and a one-step correction.
// Throughput is one pixel per cycle while the output is not stalled. Every stage has a valid bit and
// loads when empty or when its content moves on, so bubbles are squeezed
// out and a stalled output holds its result while upstream stages fill.
// Reset clears all valid bits and the corner registers to zero.
module bilinear_ray_direction_grid_unit #(
  parameter int GRID_WIDTH  = 640,
  parameter int GRID_HEIGHT = 480
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input pixel
  input  logic                           s_tvalid_i,
  output logic                           s_tready_o,
  input  logic [brdg_pkg::InDataW-1:0]   s_tdata_i,   // pixel_col[9:0], pixel_row[18:10]
  // output direction
  output logic                           m_tvalid_o,
  input  logic                           m_tready_i,
  output logic [brdg_pkg::VecW-1:0]      m_tdata_o,   // dir_x[15:0], dir_y[31:16], dir_z[47:32]
  // corner configuration
  input  logic                           cfg_we_i,
  input  logic [brdg_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [brdg_pkg::VecW-1:0]      cfg_wdata_i
);
  import brdg_pkg::*;

  localparam int ColMax = GRID_WIDTH - 1;
  localparam int RowMax = GRID_HEIGHT - 1;
  localparam int ColW   = ($clog2(GRID_WIDTH) < ColInW) ? $clog2(GRID_WIDTH) : ColInW;
  localparam int RowW   = ($clog2(GRID_HEIGHT) < RowInW) ? $clog2(GRID_HEIGHT) : RowInW;

  stage_en_t en;

  // Corner registers
  vec_t tl_q, tr_q, bl_q, br_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tl_q <= '0;
      tr_q <= '0;
      bl_q <= '0;
      br_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgTopLeft:     tl_q <= cfg_wdata_i;
        CfgTopRight:    tr_q <= cfg_wdata_i;
        CfgBottomLeft:  bl_q <= cfg_wdata_i;
        CfgBottomRight: br_q <= cfg_wdata_i;
        default:        ;
      endcase
    end
  end

  // Pipeline control
  brdg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_tvalid_i),
    .in_ready_o  (s_tready_o),
    .out_valid_o (m_tvalid_o),
    .out_ready_i (m_tready_i),
    .en_o        (en)
  );

  // Stage 0: clamp to the grid
  logic [ColInW-1:0] col_in;
  logic [RowInW-1:0] row_in;
  logic [ColW-1:0]   col0_q;
  logic [RowW-1:0]   row0_q;

  assign col_in = s_tdata_i[ColInW-1:0];
  assign row_in = s_tdata_i[ColInW +: RowInW];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      col0_q <= (int'(col_in) > ColMax) ? ColW'(ColMax) : ColW'(col_in);
      row0_q <= (int'(row_in) > RowMax) ? RowW'(RowMax) : RowW'(row_in);
    end
  end

  // Column travels beside the edge blends
  logic [ColW-1:0] col_pipe_q [BlendStages];

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      col_pipe_q[0] <= col0_q;
    end
    for (int k = 1; k < BlendStages; k++) begin
      if (en[k+1]) begin
        col_pipe_q[k] <= col_pipe_q[k-1];
      end
    end
  end

  // Per component: edges over the row, then across over the column
  logic [CompW-1:0] dir [3];

  for (genvar c = 0; c < 3; c++) begin : g_comp
    logic signed [CompW-1:0] left, right, dir_c;

    brdg_blend #(
      .DEN (RowMax),
      .NW  (RowW)
    ) u_left (
      .clk_i (clk_i),
      .en_i  (en[BlendStages:1]),
      .a_i   (tl_q[c*CompW +: CompW]),
      .b_i   (bl_q[c*CompW +: CompW]),
      .n_i   (row0_q),
      .v_o   (left)
    );

    brdg_blend #(
      .DEN (RowMax),
      .NW  (RowW)
    ) u_right (
      .clk_i (clk_i),
      .en_i  (en[BlendStages:1]),
      .a_i   (tr_q[c*CompW +: CompW]),
      .b_i   (br_q[c*CompW +: CompW]),
      .n_i   (row0_q),
      .v_o   (right)
    );

    brdg_blend #(
      .DEN (ColMax),
      .NW  (ColW)
    ) u_across (
      .clk_i (clk_i),
      .en_i  (en[NumStages-1:BlendStages+1]),
      .a_i   (left),
      .b_i   (right),
      .n_i   (col_pipe_q[BlendStages-1]),
      .v_o   (dir_c)
    );

    assign dir[c] = dir_c;
  end

  // Vector packs z low; the stream puts x low
  assign m_tdata_o = {dir[0], dir[1], dir[2]};

endmodule
